// ----- src/bb16_pkg.sv -----
package bb16_pkg;

	// Field widths
	localparam int SIDE_W  = 11;
	localparam int COORD_W = 16;
	localparam int ADDR_W  = 20;
	localparam int COLOR_W = 16;
	localparam int BYTE_W  = 8;
	localparam int BIT_W   = 3;

	// Largest framebuffer or bitmap side; larger values in the low 11 bits of a write saturate here
	localparam logic [SIDE_W-1:0] MAX_SIDE = 11'd1024;

	// APB register file
	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_FB_WIDTH     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_FB_HEIGHT    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DEST_X       = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DEST_Y       = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BMP_WIDTH    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_BMP_HEIGHT   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_INK_COLOR    = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_DROP_OUTSIDE = 3'd7;

	typedef struct packed {
		logic [BYTE_W-1:0] bitmap_byte;
	} bb16_in_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  pixel_addr;
		logic [COLOR_W-1:0] pixel_value;
		logic               last_of_run;
	} bb16_out_t;

	typedef struct packed {
		logic [SIDE_W-1:0]  fb_width;
		logic [SIDE_W-1:0]  fb_height;
		logic [COORD_W-1:0] dest_x;
		logic [COORD_W-1:0] dest_y;
		logic [SIDE_W-1:0]  bmp_width;
		logic [SIDE_W-1:0]  bmp_height;
		logic [COLOR_W-1:0] ink_color;
		logic               drop_outside;
	} bb16_cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic restart;    // rewind to first byte, reload coordinates
		logic div_start;  // launch remainder unit
		logic div_sel_y;  // 0: dest_x % fb_width, 1: dest_y % fb_height
		logic load_col;   // take column remainder
		logic load_page;  // take row remainder
		logic load_base;  // row base address = page * fb_width
		logic accept;     // capture byte, build write mask
		logic step;       // advance one column
		logic emit;       // load output register
		logic end_byte;   // byte finished, move byte/row position
	} bb16_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic div_done;
		logic live;       // current byte position lies inside the bitmap
		logic emit_now;   // current column produces a write
	} bb16_sts_t;

endpackage

// ----- src/bb16_stream_if.sv -----
interface bb16_stream_if #(
	parameter type T = logic [7:0]
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- src/mono_bitmap_blit_16bpp_top.sv -----
// Monochrome bitmap blit into a 16-bit framebuffer. Bitmap bytes come in on the bitmap
// channel in row-major order, leftmost pixel in bit 7, rows padded to whole bytes; every
// set bit inside bmp_width yields one transaction on the pixels channel carrying the
// framebuffer word address (row * fb_width + column), ink_color, and last_of_run on the
// final write of that byte, unless a framebuffer side is zero or drop_outside skips it
// outside the framebuffer. A byte inside the bitmap is accepted, then walked through a
// single output register one column per cycle, written or not, unless the pixels sink
// stalls a write; bitmap ready is low until the walk ends. Bytes past the last row or
// with bmp_width zero give nothing. After reset and every register write the block rewinds
// to the first bitmap byte and, with bitmap ready low, reduces dest_x and dest_y modulo the
// framebuffer size in a bit-serial remainder unit and forms the first row base address.
module mono_bitmap_blit_16bpp_top (
	input  logic                          clk,
	input  logic                          arst_n,
	bb16_stream_if.sink                   bitmap,
	bb16_stream_if.source                 pixels,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bb16_pkg::PADDR_W-1:0]  paddr,
	input  logic [bb16_pkg::PDATA_W-1:0]  pwdata,
	output logic [bb16_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	bb16_pkg::bb16_cfg_t  cfg;
	bb16_pkg::bb16_cmd_t  cmd;
	bb16_pkg::bb16_sts_t  sts;
	bb16_pkg::bb16_out_t  result;
	logic                 restart;
	logic                 in_ready;
	logic                 out_valid;

	bb16_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.restart (restart)
	);

	bb16_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (restart),
		.in_valid  (bitmap.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (pixels.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bb16_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.bitmap_byte (bitmap.data.bitmap_byte),
		.sts         (sts),
		.result      (result)
	);

	assign bitmap.ready = in_ready;
	assign pixels.valid = out_valid;
	assign pixels.data  = result;

endmodule

// ----- src/bb16_regs.sv -----
module bb16_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bb16_pkg::PADDR_W-1:0]   paddr,
	input  logic [bb16_pkg::PDATA_W-1:0]   pwdata,
	output logic [bb16_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	output bb16_pkg::bb16_cfg_t            cfg,
	output logic                           restart
);

	bb16_pkg::bb16_cfg_t                  cfg_q;
	logic [bb16_pkg::REG_IDX_W-1:0]       idx;
	logic                                 wr;
	logic [bb16_pkg::SIDE_W-1:0]          side_val;

	// Saturate oversized sides
	function automatic logic [bb16_pkg::SIDE_W-1:0] clamp_side(
		input logic [bb16_pkg::SIDE_W-1:0] v
	);
		return (v > bb16_pkg::MAX_SIDE) ? bb16_pkg::MAX_SIDE : v;
	endfunction

	assign idx      = paddr[bb16_pkg::PADDR_W-1:2];
	assign wr       = psel & penable & pwrite;
	assign pready   = 1'b1;
	assign restart  = wr;
	assign cfg      = cfg_q;
	assign side_val = clamp_side(pwdata[bb16_pkg::SIDE_W-1:0]);

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fb_width     <= 11'd320;
			cfg_q.fb_height    <= 11'd240;
			cfg_q.dest_x       <= '0;
			cfg_q.dest_y       <= '0;
			cfg_q.bmp_width    <= 11'd8;
			cfg_q.bmp_height   <= 11'd8;
			cfg_q.ink_color    <= 16'hFFFF;
			cfg_q.drop_outside <= 1'b0;
		end else if (wr) begin
			unique case (idx)
				bb16_pkg::REG_FB_WIDTH:     cfg_q.fb_width     <= side_val;
				bb16_pkg::REG_FB_HEIGHT:    cfg_q.fb_height    <= side_val;
				bb16_pkg::REG_DEST_X:       cfg_q.dest_x       <= pwdata[bb16_pkg::COORD_W-1:0];
				bb16_pkg::REG_DEST_Y:       cfg_q.dest_y       <= pwdata[bb16_pkg::COORD_W-1:0];
				bb16_pkg::REG_BMP_WIDTH:    cfg_q.bmp_width    <= side_val;
				bb16_pkg::REG_BMP_HEIGHT:   cfg_q.bmp_height   <= side_val;
				bb16_pkg::REG_INK_COLOR:    cfg_q.ink_color    <= pwdata[bb16_pkg::COLOR_W-1:0];
				bb16_pkg::REG_DROP_OUTSIDE: cfg_q.drop_outside <= pwdata[0];
				default:                    cfg_q              <= cfg_q;
			endcase
		end
	end

	// Readback
	always_comb begin
		unique case (idx)
			bb16_pkg::REG_FB_WIDTH:     prdata = 32'(cfg_q.fb_width);
			bb16_pkg::REG_FB_HEIGHT:    prdata = 32'(cfg_q.fb_height);
			bb16_pkg::REG_DEST_X:       prdata = 32'(cfg_q.dest_x);
			bb16_pkg::REG_DEST_Y:       prdata = 32'(cfg_q.dest_y);
			bb16_pkg::REG_BMP_WIDTH:    prdata = 32'(cfg_q.bmp_width);
			bb16_pkg::REG_BMP_HEIGHT:   prdata = 32'(cfg_q.bmp_height);
			bb16_pkg::REG_INK_COLOR:    prdata = 32'(cfg_q.ink_color);
			bb16_pkg::REG_DROP_OUTSIDE: prdata = 32'(cfg_q.drop_outside);
			default:                    prdata = '0;
		endcase
	end

endmodule

// ----- src/bb16_rem.sv -----
module bb16_rem (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bb16_pkg::COORD_W-1:0]  dividend,
	input  logic [bb16_pkg::SIDE_W-1:0]   divisor,
	output logic                          done,
	output logic [bb16_pkg::SIDE_W-1:0]   rem
);

	localparam int CNT_W = $clog2(bb16_pkg::COORD_W + 1);

	logic                          busy_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [bb16_pkg::COORD_W-1:0]  dvd_q;
	logic [bb16_pkg::SIDE_W-1:0]   dsr_q;
	logic [bb16_pkg::SIDE_W-1:0]   rem_q;
	logic [bb16_pkg::SIDE_W:0]     trial;
	logic                          fits;

	// One restoring step per cycle, MSB of the dividend first
	assign trial = {rem_q, dvd_q[bb16_pkg::COORD_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};
	assign done  = busy_q && (cnt_q == '0);
	assign rem   = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(bb16_pkg::COORD_W);
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q && (cnt_q != '0)) begin
			dvd_q <= {dvd_q[bb16_pkg::COORD_W-2:0], 1'b0};
			rem_q <= fits ? bb16_pkg::SIDE_W'(trial - {1'b0, dsr_q})
			              : trial[bb16_pkg::SIDE_W-1:0];
		end
	end

endmodule

// ----- src/bb16_dp.sv -----
module bb16_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bb16_pkg::bb16_cfg_t          cfg,
	input  bb16_pkg::bb16_cmd_t          cmd,
	input  logic [bb16_pkg::BYTE_W-1:0]  bitmap_byte,
	output bb16_pkg::bb16_sts_t          sts,
	output bb16_pkg::bb16_out_t          result
);

	localparam int SW = bb16_pkg::SIDE_W;
	localparam int CW = bb16_pkg::COORD_W;
	localparam int AW = bb16_pkg::ADDR_W;
	localparam int BW = bb16_pkg::BYTE_W;

	// Walk position
	logic [SW-1:0]   row_q;
	logic [BW-1:0]   byte_q;
	logic [CW-1:0]   x_q;
	logic [CW-1:0]   y_q;
	logic [SW-1:0]   col_q;
	logic [SW-1:0]   col_base_q;
	logic [SW-1:0]   page_q;
	logic [AW-1:0]   row_base_q;
	logic [BW-1:0]   emit_q;
	bb16_pkg::bb16_out_t out_q;

	logic [CW-1:0]   div_dvd;
	logic [SW-1:0]   div_dsr;
	logic            div_done;
	logic [SW-1:0]   div_rem;

	logic [2*SW-1:0] prod;
	logic [BW-1:0]   mask;
	logic [BW-1:0]   bytes_per_row;
	logic            row_end;
	logic            fb_ok;
	logic            y_in;
	logic [SW-1:0]   col_inc;
	logic [SW-1:0]   col_nxt;
	logic [SW-1:0]   page_inc;
	logic [SW-1:0]   page_nxt;
	logic [AW-1:0]   base_nxt;

	// Shared remainder unit for the start coordinates
	assign div_dvd = cmd.div_sel_y ? cfg.dest_y : cfg.dest_x;
	assign div_dsr = cmd.div_sel_y ? cfg.fb_height : cfg.fb_width;

	bb16_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.rem      (div_rem)
	);

	assign prod = page_q * cfg.fb_width;

	// Row bookkeeping
	assign bytes_per_row = BW'((cfg.bmp_width + SW'(BW - 1)) >> 3);
	assign row_end       = ({1'b0, byte_q} + 1'b1) >= {1'b0, bytes_per_row};
	assign fb_ok         = (cfg.fb_width != '0) && (cfg.fb_height != '0);
	assign y_in          = y_q < CW'(cfg.fb_height);

	// Column and row advance with wrap at framebuffer size and at 16 bits
	assign col_inc  = col_q + 1'b1;
	assign col_nxt  = ((x_q == '1) || (col_inc == cfg.fb_width)) ? '0 : col_inc;
	assign page_inc = page_q + 1'b1;
	assign page_nxt = ((y_q == '1) || (page_inc == cfg.fb_height)) ? '0 : page_inc;
	assign base_nxt = ((y_q == '1) || (page_inc == cfg.fb_height)) ? '0
	                : AW'(row_base_q + AW'(cfg.fb_width));

	// Write mask of the byte, first column in the top bit
	always_comb begin
		logic [SW-1:0] cbase;
		logic [SW-1:0] c;
		logic [CW-1:0] x;
		logic          ok;
		cbase = SW'({byte_q, 3'b000});
		mask  = '0;
		for (int b = 0; b < BW; b++) begin
			c  = cbase + SW'(b);
			x  = x_q + CW'(b);
			ok = !cfg.drop_outside || ((x < CW'(cfg.fb_width)) && y_in);
			mask[BW-1-b] = bitmap_byte[BW-1-b] && (c < cfg.bmp_width) && ok && fb_ok;
		end
	end

	// Position and mask state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			byte_q <= '0;
			emit_q <= '0;
		end else begin
			priority if (cmd.restart) begin
				row_q  <= '0;
				byte_q <= '0;
			end else if (cmd.end_byte) begin
				if (row_end) begin
					byte_q <= '0;
					row_q  <= row_q + 1'b1;
				end else begin
					byte_q <= byte_q + 1'b1;
				end
			end
			priority if (cmd.accept) begin
				emit_q <= mask;
			end else if (cmd.step) begin
				emit_q <= {emit_q[BW-2:0], 1'b0};
			end
		end
	end

	// Coordinates, bases and output register
	always_ff @(posedge clk) begin
		if (cmd.restart) begin
			x_q <= cfg.dest_x;
			y_q <= cfg.dest_y;
		end
		if (cmd.load_col) begin
			col_q      <= div_rem;
			col_base_q <= div_rem;
		end
		if (cmd.load_page) begin
			page_q <= div_rem;
		end
		if (cmd.load_base) begin
			row_base_q <= AW'(prod);
		end
		priority if (cmd.end_byte && row_end) begin
			x_q        <= cfg.dest_x;
			col_q      <= col_base_q;
			y_q        <= y_q + 1'b1;
			page_q     <= page_nxt;
			row_base_q <= base_nxt;
		end else if (cmd.step) begin
			x_q   <= x_q + 1'b1;
			col_q <= col_nxt;
		end
		if (cmd.emit) begin
			out_q.pixel_addr  <= AW'(row_base_q + AW'(col_q));
			out_q.pixel_value <= cfg.ink_color;
			out_q.last_of_run <= ~|emit_q[BW-2:0];
		end
	end

	assign sts.div_done = div_done;
	assign sts.live     = (cfg.bmp_width != '0) && (row_q < cfg.bmp_height);
	assign sts.emit_now = emit_q[BW-1];
	assign result       = out_q;

endmodule

// ----- src/bb16_ctrl.sv -----
module bb16_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 restart,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  bb16_pkg::bb16_sts_t  sts,
	output bb16_pkg::bb16_cmd_t  cmd
);

	localparam logic [2:0] ST_START   = 3'd0;
	localparam logic [2:0] ST_SETUP_X = 3'd1;
	localparam logic [2:0] ST_SETUP_Y = 3'd2;
	localparam logic [2:0] ST_SETUP_M = 3'd3;
	localparam logic [2:0] ST_IDLE    = 3'd4;
	localparam logic [2:0] ST_WALK    = 3'd5;

	localparam logic [bb16_pkg::BIT_W-1:0] LAST_BIT = bb16_pkg::BIT_W'(bb16_pkg::BYTE_W - 1);

	logic [2:0]                    state_q, state_d;
	logic [bb16_pkg::BIT_W-1:0]    bit_q, bit_d;
	logic                          out_valid_q;
	logic                          stall;

	// Hold the column while its write cannot enter the output register
	assign stall = sts.emit_now && out_valid_q && !out_ready;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		bit_d    = bit_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_START: begin
				cmd.restart   = 1'b1;
				cmd.div_start = 1'b1;
				state_d       = ST_SETUP_X;
			end
			ST_SETUP_X: begin
				if (sts.div_done) begin
					cmd.load_col  = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel_y = 1'b1;
					state_d       = ST_SETUP_Y;
				end
			end
			ST_SETUP_Y: begin
				if (sts.div_done) begin
					cmd.load_page = 1'b1;
					state_d       = ST_SETUP_M;
				end
			end
			ST_SETUP_M: begin
				cmd.load_base = 1'b1;
				state_d       = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = !restart;
				if (in_valid && !restart) begin
					cmd.accept = 1'b1;
					if (sts.live) begin
						bit_d   = '0;
						state_d = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				if (!stall) begin
					cmd.step = 1'b1;
					cmd.emit = sts.emit_now;
					bit_d    = bit_q + 1'b1;
					if (bit_q == LAST_BIT) begin
						cmd.end_byte = 1'b1;
						state_d      = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_START;
			end
		endcase
		// A register write rewinds the walk
		if (restart) begin
			state_d = ST_START;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_START;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			bit_q   <= bit_d;
			priority if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- src/bb16_chk.sv -----
module bb16_chk (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_ready,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  bb16_pkg::bb16_out_t  out_data,
	input  logic                 cfg_wr
);

	// Register write rewinds: no byte taken in the next cycle
	a_cfg_block: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> !in_ready)
		else $error("bitmap ready high right after a register write");

	// Coordinate setup after a register write still holds bitmap ready low
	a_setup_len: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |-> ##34 !in_ready)
		else $error("bitmap ready high before coordinate setup finished");

	// A waiting pixel write holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("pixel write dropped or changed while stalled");

	// Nothing offered or taken while in reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid && !in_ready)
		else $error("handshake active during reset");

endmodule

bind mono_bitmap_blit_16bpp_top bb16_chk u_bb16_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (bitmap.ready),
	.out_valid (pixels.valid),
	.out_ready (pixels.ready),
	.out_data  (pixels.data),
	.cfg_wr    (psel & penable & pwrite & pready)
);

// ----- dv/mono_bitmap_blit_16bpp_top_tb.sv -----
module mono_bitmap_blit_16bpp_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [bb16_pkg::PADDR_W-1:0] paddr;
	logic [bb16_pkg::PDATA_W-1:0] pwdata;
	logic [bb16_pkg::PDATA_W-1:0] prdata;
	logic pready;

	bb16_stream_if #(.T(bb16_pkg::bb16_in_t))  bitmap_ch ();
	bb16_stream_if #(.T(bb16_pkg::bb16_out_t)) pixels_ch ();

	mono_bitmap_blit_16bpp_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bitmap  (bitmap_ch),
		.pixels  (pixels_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Predicted block state and register shadow
	bb16_pkg::bb16_cfg_t         blit_cfg;
	logic [bb16_pkg::SIDE_W-1:0] blit_row;
	logic [7:0]                  blit_byte;

	// Pixel writes predicted but not yet seen
	bb16_pkg::bb16_out_t pending_pixels[$];

	int err_count = 0;
	bit sender_free = 1'b0;
	bit sink_free = 1'b0;
	int sink_hold = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit
	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Random gap length: mostly short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (sender_free || r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	function automatic logic [bb16_pkg::SIDE_W-1:0] clamp_side(input logic [31:0] v);
		return (v[bb16_pkg::SIDE_W-1:0] > bb16_pkg::MAX_SIDE) ? bb16_pkg::MAX_SIDE
			: v[bb16_pkg::SIDE_W-1:0];
	endfunction

	// Register write as seen by the predictor; every write rewinds the walk
	function automatic void shadow_reg(
		input logic [bb16_pkg::REG_IDX_W-1:0] idx,
		input logic [31:0] v
	);
		case (idx)
			bb16_pkg::REG_FB_WIDTH:     blit_cfg.fb_width = clamp_side(v);
			bb16_pkg::REG_FB_HEIGHT:    blit_cfg.fb_height = clamp_side(v);
			bb16_pkg::REG_DEST_X:       blit_cfg.dest_x = v[bb16_pkg::COORD_W-1:0];
			bb16_pkg::REG_DEST_Y:       blit_cfg.dest_y = v[bb16_pkg::COORD_W-1:0];
			bb16_pkg::REG_BMP_WIDTH:    blit_cfg.bmp_width = clamp_side(v);
			bb16_pkg::REG_BMP_HEIGHT:   blit_cfg.bmp_height = clamp_side(v);
			bb16_pkg::REG_INK_COLOR:    blit_cfg.ink_color = v[bb16_pkg::COLOR_W-1:0];
			bb16_pkg::REG_DROP_OUTSIDE: blit_cfg.drop_outside = v[0];
			default: ;
		endcase
		blit_row = '0;
		blit_byte = '0;
	endfunction

	// Pixel writes caused by one bitmap byte; returns 1 if the byte lies inside the bitmap
	function automatic bit predict_byte_writes(input logic [7:0] b);
		bb16_pkg::bb16_out_t run[$];
		bb16_pkg::bb16_out_t w;
		int unsigned bytes_per_row, y, c, x, page, col;
		if (blit_cfg.bmp_width == 0 || blit_row >= blit_cfg.bmp_height)
			return 1'b0;
		y = (blit_cfg.dest_y + blit_row) & 32'hFFFF;
		for (int i = 0; i < 8; i++) begin
			c = blit_byte * 8 + i;
			if (c >= blit_cfg.bmp_width)
				break;
			if (!b[7-i])
				continue;
			if (blit_cfg.fb_width == 0 || blit_cfg.fb_height == 0)
				continue;
			x = (blit_cfg.dest_x + c) & 32'hFFFF;
			if (blit_cfg.drop_outside && (x >= blit_cfg.fb_width || y >= blit_cfg.fb_height))
				continue;
			col = x % blit_cfg.fb_width;
			page = y % blit_cfg.fb_height;
			w.pixel_addr = bb16_pkg::ADDR_W'(page * blit_cfg.fb_width + col);
			w.pixel_value = blit_cfg.ink_color;
			w.last_of_run = 1'b0;
			run.push_back(w);
		end
		foreach (run[k]) begin
			w = run[k];
			w.last_of_run = (k == run.size() - 1);
			pending_pixels.push_back(w);
		end
		// advance byte / row position
		bytes_per_row = (blit_cfg.bmp_width + 7) / 8;
		if (blit_byte + 1 >= bytes_per_row) begin
			blit_byte = '0;
			blit_row = blit_row + 1'b1;
		end else begin
			blit_byte = blit_byte + 1'b1;
		end
		return 1'b1;
	endfunction

	// One bitmap byte transaction; valid stays up for a back-to-back follower
	task automatic send_byte(input logic [7:0] b, output bit live);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			bitmap_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		bitmap_ch.valid <= 1'b1;
		bitmap_ch.data <= '{bitmap_byte: b};
		do @(posedge clk); while (!bitmap_ch.ready);
		live = predict_byte_writes(b);
	endtask

	// APB write: setup, access, then back to idle
	task automatic apb_write(input logic [bb16_pkg::REG_IDX_W-1:0] idx, input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		shadow_reg(idx, v);
		@(posedge clk);
	endtask

	task automatic wait_drained();
		bitmap_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_pixels.size() != 0);
	endtask

	// Drained, plus room for a byte still walking columns without writes
	task automatic settle_block();
		wait_drained();
		repeat (12) @(posedge clk);
	endtask

	// Pixel sink: random stalls
	always @(posedge clk) begin
		if (sink_hold > 0) begin
			sink_hold--;
			pixels_ch.ready <= 1'b0;
		end else begin
			pixels_ch.ready <= 1'b1;
			if (!sink_free && $urandom_range(0, 3) == 0)
				sink_hold = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3) :
					$urandom_range(8, 30);
		end
	end

	// Compare each pixel transaction with the oldest prediction
	always @(posedge clk) begin : check_pixels
		bb16_pkg::bb16_out_t want;
		if (arst_n === 1'b1 && pixels_ch.valid && pixels_ch.ready) begin
			if (pending_pixels.size() == 0) begin
				$error("unexpected pixel write addr=%0h value=%0h",
					pixels_ch.data.pixel_addr, pixels_ch.data.pixel_value);
				err_count++;
			end else begin
				want = pending_pixels.pop_front();
				if (pixels_ch.data.pixel_addr !== want.pixel_addr) begin
					$error("pixel_addr expected %0h actual %0h",
						want.pixel_addr, pixels_ch.data.pixel_addr);
					err_count++;
				end
				if (pixels_ch.data.pixel_value !== want.pixel_value) begin
					$error("pixel_value expected %0h actual %0h",
						want.pixel_value, pixels_ch.data.pixel_value);
					err_count++;
				end
				if (pixels_ch.data.last_of_run !== want.last_of_run) begin
					$error("last_of_run expected %0b actual %0b",
						want.last_of_run, pixels_ch.data.last_of_run);
					err_count++;
				end
			end
		end
	end

	// Reset geometry: 8x8 bitmap into 320x240, then bytes past the last row
	task automatic test_default_blit();
		logic [7:0] seq [10] = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'hAA, 8'h55, 8'hFF, 8'h81,
			8'hFF, 8'hFF};
		bit live;
		foreach (seq[i])
			send_byte(seq[i], live);
	endtask

	// Saturating sizes, coordinates wrapping past 0xFFFF, pad bits in a 13-wide row
	task automatic test_clamp_and_wrap();
		logic [7:0] seq [5] = '{8'hFF, 8'hFF, 8'h5A, 8'hFF, 8'hFF};
		bit live;
		settle_block();
		apb_write(bb16_pkg::REG_FB_WIDTH, 32'h0000_07FF);
		apb_write(bb16_pkg::REG_FB_HEIGHT, 32'h0000_0500);
		apb_write(bb16_pkg::REG_DEST_X, 32'h0000_FFFA);
		apb_write(bb16_pkg::REG_DEST_Y, 32'h0000_FFFF);
		apb_write(bb16_pkg::REG_BMP_WIDTH, 32'd13);
		apb_write(bb16_pkg::REG_BMP_HEIGHT, 32'd2);
		apb_write(bb16_pkg::REG_INK_COLOR, 32'h0000_0000);
		apb_write(bb16_pkg::REG_DROP_OUTSIDE, 32'd0);
		foreach (seq[i])
			send_byte(seq[i], live);
	endtask

	// Drop mode: columns at and past fb_width, rows at and past fb_height are skipped
	task automatic test_drop_edges();
		bit live;
		settle_block();
		apb_write(bb16_pkg::REG_FB_WIDTH, 32'd16);
		apb_write(bb16_pkg::REG_FB_HEIGHT, 32'd4);
		apb_write(bb16_pkg::REG_DEST_X, 32'd10);
		apb_write(bb16_pkg::REG_DEST_Y, 32'd2);
		apb_write(bb16_pkg::REG_BMP_WIDTH, 32'd12);
		apb_write(bb16_pkg::REG_BMP_HEIGHT, 32'd3);
		apb_write(bb16_pkg::REG_INK_COLOR, 32'h0000_A5C3);
		apb_write(bb16_pkg::REG_DROP_OUTSIDE, 32'd1);
		repeat (6)
			send_byte(8'hFF, live);
	endtask

	// Zero framebuffer sides, zero bitmap width and height
	task automatic test_zero_sizes();
		bit live;
		settle_block();
		apb_write(bb16_pkg::REG_FB_WIDTH, 32'd0);
		send_byte(8'hFF, live);
		send_byte(8'hFF, live);
		settle_block();
		apb_write(bb16_pkg::REG_FB_WIDTH, 32'd8);
		apb_write(bb16_pkg::REG_FB_HEIGHT, 32'd0);
		send_byte(8'hFF, live);
		settle_block();
		apb_write(bb16_pkg::REG_FB_HEIGHT, 32'd8);
		apb_write(bb16_pkg::REG_DEST_X, 32'd0);
		// upper bits ignored: width becomes zero
		apb_write(bb16_pkg::REG_BMP_WIDTH, 32'hFFFF_F800);
		send_byte(8'hFF, live);
		settle_block();
		apb_write(bb16_pkg::REG_BMP_WIDTH, 32'd5);
		apb_write(bb16_pkg::REG_BMP_HEIGHT, 32'd0);
		send_byte(8'hFF, live);
		settle_block();
		apb_write(bb16_pkg::REG_BMP_HEIGHT, 32'd1);
		send_byte(8'hFF, live);
	endtask

	function automatic logic [31:0] rand_side();
		case ($urandom_range(0, 9))
			0: return 32'd1;
			1: return 32'd1024;
			2: return $urandom_range(1025, 2047);
			3: return $urandom();
			default: return $urandom_range(1, 64);
		endcase
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0, 1: return $urandom_range(0, 70);
			2: return $urandom_range(65500, 65535);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] rand_reg_value(input logic [bb16_pkg::REG_IDX_W-1:0] idx);
		case (idx)
			bb16_pkg::REG_FB_WIDTH, bb16_pkg::REG_FB_HEIGHT: return rand_side();
			bb16_pkg::REG_DEST_X, bb16_pkg::REG_DEST_Y: return rand_coord();
			bb16_pkg::REG_BMP_WIDTH:
				case ($urandom_range(0, 9))
					0: return 32'd0;
					1: return $urandom_range(25, 1024);
					2: return $urandom();
					default: return $urandom_range(1, 24);
				endcase
			bb16_pkg::REG_BMP_HEIGHT:
				case ($urandom_range(0, 9))
					0: return 32'd0;
					1: return 32'h0000_07FF;
					default: return $urandom_range(1, 5);
				endcase
			bb16_pkg::REG_INK_COLOR: return $urandom();
			default: return $urandom_range(0, 1);
		endcase
	endfunction

	// Random geometry per phase, then a short run of random bytes
	task automatic test_random_blits();
		logic [bb16_pkg::REG_IDX_W-1:0] ridx;
		int sent, nbytes, total, ph;
		bit live;
		sent = 0;
		ph = 0;
		while (sent < 44) begin
			settle_block();
			sender_free = ($urandom_range(0, 3) == 0);
			sink_free = ($urandom_range(0, 3) == 0);
			for (int r = 0; r < 8; r++) begin
				ridx = bb16_pkg::REG_IDX_W'(r);
				if (ph == 0 || $urandom_range(0, 9) < 7)
					apb_write(ridx, rand_reg_value(ridx));
			end
			total = ((blit_cfg.bmp_width + 7) / 8) * blit_cfg.bmp_height;
			nbytes = (total > 16) ? 16 : total;
			nbytes += $urandom_range(0, 2);
			for (int i = 0; i < nbytes; i++) begin
				// hold the sender until the sink has caught up
				if (ph == 0 && i == nbytes / 2)
					wait_drained();
				send_byte(8'($urandom_range(0, 255)), live);
				sent++;
			end
			ph++;
		end
		sender_free = 1'b0;
		sink_free = 1'b0;
	endtask

	// One full row at the widest bitmap, byte position runs to its end
	task automatic test_widest_row();
		bit live;
		settle_block();
		apb_write(bb16_pkg::REG_FB_WIDTH, 32'd1024);
		apb_write(bb16_pkg::REG_FB_HEIGHT, 32'd1);
		apb_write(bb16_pkg::REG_DEST_X, rand_coord());
		apb_write(bb16_pkg::REG_DEST_Y, rand_coord());
		apb_write(bb16_pkg::REG_BMP_WIDTH, 32'h0000_07FF);
		apb_write(bb16_pkg::REG_BMP_HEIGHT, 32'd1);
		apb_write(bb16_pkg::REG_DROP_OUTSIDE, $urandom_range(0, 1));
		repeat (129)
			send_byte(8'($urandom_range(0, 255)), live);
	endtask

	initial begin
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		bitmap_ch.valid = 1'b0;
		bitmap_ch.data = '0;
		pixels_ch.ready = 1'b0;
		blit_cfg = '{fb_width: 11'd320, fb_height: 11'd240, dest_x: 16'd0, dest_y: 16'd0,
			bmp_width: 11'd8, bmp_height: 11'd8, ink_color: 16'hFFFF, drop_outside: 1'b0};
		blit_row = '0;
		blit_byte = '0;
		// apply reset once every process is waiting on it
		#1;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_blit();
		test_clamp_and_wrap();
		test_drop_edges();
		test_zero_sizes();
		test_random_blits();
		test_widest_row();

		settle_block();
		repeat (20) @(posedge clk);
		if (pending_pixels.size() != 0) begin
			$error("%0d predicted pixel writes never arrived", pending_pixels.size());
			err_count++;
		end
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- files.f -----
src/bb16_pkg.sv
src/bb16_stream_if.sv
src/bb16_regs.sv
src/bb16_rem.sv
src/bb16_dp.sv
src/bb16_ctrl.sv
src/mono_bitmap_blit_16bpp_top.sv
src/bb16_chk.sv
dv/mono_bitmap_blit_16bpp_top_tb.sv
